@@ rtl/ev1527_ook_frame_encoder_assert.svh @@
// Assertion macros for the EV1527 OOK frame encoder checker.
// No dependencies; included by the checker file only.
`ifndef EV1527_OOK_FRAME_ENCODER_ASSERT_SVH
`define EV1527_OOK_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EV1527_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ev1527 assertion failed");

// Next-cycle implication, disabled during reset.
`define EV1527_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ev1527 assertion failed");

`endif

@@ rtl/ev1527_pkg.sv @@
// Shared types and constants for the EV1527 OOK frame encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ev1527_pkg;

    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int ADDR_W       = 16;
    localparam int CODE_W       = 8;
    localparam int REPEAT_W     = 8;
    localparam int FRAME_BITS   = ADDR_W + CODE_W;
    localparam int SEG_W        = 6;
    localparam int SEGS_PER_FRAME = 50;
    localparam int TICK_BITS_DEF  = 16;

    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SEGS_PER_FRAME - 1);

    // Register reset values
    localparam logic [ADDR_W-1:0]   ADDR_RST   = 16'd0;
    localparam logic [CFG_W-1:0]    SHORT_RST  = 16'd186;
    localparam logic [CFG_W-1:0]    LONG_RST   = 16'd558;
    localparam logic [CFG_W-1:0]    SYNC_RST   = 16'd5767;
    localparam logic [REPEAT_W-1:0] REPEAT_RST = 8'd20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd4;

    // Input action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]   device_address;
        logic [CFG_W-1:0]    short_ticks;
        logic [CFG_W-1:0]    long_ticks;
        logic [CFG_W-1:0]    sync_gap_ticks;
        logic [REPEAT_W-1:0] repeat_count;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic done_res;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/ev1527_cfg.sv @@
// Configuration register bank for the EV1527 OOK frame encoder.
// Depends on ev1527_pkg.
`default_nettype none

module ev1527_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr,
    input  wire logic [ev1527_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [ev1527_pkg::CFG_W-1:0]     i_data,
    output ev1527_pkg::t_cfg                      o_cfg
);
    import ev1527_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= ADDR_RST;
            r_cfg.short_ticks    <= SHORT_RST;
            r_cfg.long_ticks     <= LONG_RST;
            r_cfg.sync_gap_ticks <= SYNC_RST;
            r_cfg.repeat_count   <= REPEAT_RST;
        end else if (i_wr) begin
            unique case (i_index)
                REG_ADDR:   r_cfg.device_address <= i_data[ADDR_W-1:0];
                REG_SHORT:  r_cfg.short_ticks    <= i_data;
                REG_LONG:   r_cfg.long_ticks     <= i_data;
                REG_SYNC:   r_cfg.sync_gap_ticks <= i_data;
                REG_REPEAT: r_cfg.repeat_count   <= i_data[REPEAT_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/ev1527_seq.sv @@
// Frame sequencer: segment, tick and repeat counters with next-state logic.
// Depends on ev1527_pkg; configuration arrives as a t_cfg struct.
`default_nettype none

module ev1527_seq #(
    parameter int TICK_BITS = ev1527_pkg::TICK_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_action,
    input  wire logic [ev1527_pkg::CODE_W-1:0] i_code,
    input  ev1527_pkg::t_cfg                   i_cfg,
    output ev1527_pkg::t_result                o_res
);
    import ev1527_pkg::*;

    localparam int WideW = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
    localparam logic [WideW-1:0] TickMax = WideW'((64'd1 << TICK_BITS) - 64'd1);

    // Zero counts as one tick; saturate to the counter range.
    function automatic logic [TICK_BITS-1:0] fit_ticks(input logic [CFG_W-1:0] t);
        logic [WideW-1:0] w;
        w = WideW'(t);
        if (t == '0) begin
            return TICK_BITS'(1);
        end else if (w > TickMax) begin
            return TICK_BITS'(TickMax);
        end
        return TICK_BITS'(w);
    endfunction

    logic                  r_sending, n_sending;
    logic [REPEAT_W-1:0]   r_repeats, n_repeats;
    logic [SEG_W-1:0]      r_seg,     n_seg;
    logic [TICK_BITS-1:0]  r_ticks,   n_ticks;
    logic [FRAME_BITS-1:0] r_frame,   n_frame;
    logic                  r_line,    n_line;

    logic                  done;
    logic [SEG_W-1:0]      ld_seg;
    logic [4:0]            bit_pos;
    logic [4:0]            bit_idx;
    logic                  frame_bit;
    logic [CFG_W-1:0]      ld_dur;

    // Duration of the segment following the current one
    always_comb begin
        ld_seg    = (r_seg == LAST_SEG) ? '0 : r_seg + SEG_W'(1);
        bit_pos   = ld_seg[5:1];
        bit_idx   = (bit_pos == '0) ? '0 : 5'(FRAME_BITS) - bit_pos;
        frame_bit = r_frame[bit_idx];
        if (ld_seg == '0) begin
            ld_dur = i_cfg.short_ticks;
        end else if (ld_seg == SEG_W'(1)) begin
            ld_dur = i_cfg.sync_gap_ticks;
        end else if (!ld_seg[0]) begin
            ld_dur = frame_bit ? i_cfg.long_ticks : i_cfg.short_ticks;
        end else begin
            ld_dur = frame_bit ? i_cfg.short_ticks : i_cfg.long_ticks;
        end
    end

    always_comb begin
        n_sending = r_sending;
        n_repeats = r_repeats;
        n_seg     = r_seg;
        n_ticks   = r_ticks;
        n_frame   = r_frame;
        n_line    = r_line;
        done      = 1'b0;
        if (i_step) begin
            if (i_action == ACT_START) begin
                // Ignore a start while a transmission runs
                if (!r_sending) begin
                    n_frame   = {i_cfg.device_address, i_code};
                    n_repeats = (i_cfg.repeat_count == '0) ? REPEAT_W'(1)
                                                           : i_cfg.repeat_count;
                    n_seg     = '0;
                    n_sending = 1'b1;
                    n_line    = 1'b1;
                    n_ticks   = fit_ticks(i_cfg.short_ticks);
                end
            end else if (r_sending) begin
                if (r_ticks == TICK_BITS'(1)) begin
                    n_seg = ld_seg;
                    if (r_seg == LAST_SEG && r_repeats == REPEAT_W'(1)) begin
                        n_repeats = '0;
                        n_sending = 1'b0;
                        n_line    = 1'b0;
                        n_ticks   = '0;
                        done      = 1'b1;
                    end else begin
                        if (r_seg == LAST_SEG) begin
                            n_repeats = r_repeats - REPEAT_W'(1);
                        end
                        n_line  = ~ld_seg[0];
                        n_ticks = fit_ticks(ld_dur);
                    end
                end else begin
                    n_ticks = r_ticks - TICK_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_repeats <= '0;
            r_seg     <= '0;
            r_ticks   <= '0;
            r_frame   <= '0;
            r_line    <= 1'b0;
        end else begin
            r_sending <= n_sending;
            r_repeats <= n_repeats;
            r_seg     <= n_seg;
            r_ticks   <= n_ticks;
            r_frame   <= n_frame;
            r_line    <= n_line;
        end
    end

    assign o_res.line_level = n_line;
    assign o_res.busy_res   = n_sending;
    assign o_res.done_res   = done;

endmodule

`default_nettype wire

@@ rtl/ev1527_ook_frame_encoder.sv @@
// EV1527-style OOK frame encoder. Each accepted item (a tick or a start) gives one
// result: the line level, busy and done flags after that item. Throughput is one
// item per clock; the result shows in the output register in the cycle after the
// transfer, and input ready drops only while that register is full and stalled.
// Segment timing is counted in tick items by a TICK_BITS-wide down counter;
// configuration writes are taken in any cycle.
`default_nettype none

module ev1527_ook_frame_encoder #(
    parameter int TICK_BITS = ev1527_pkg::TICK_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_action,
    input  wire logic [ev1527_pkg::CODE_W-1:0]    i_code,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_line_level,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ev1527_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ev1527_pkg::CFG_W-1:0]     i_cfg_data
);
    import ev1527_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;

    ev1527_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ev1527_seq #(
        .TICK_BITS (TICK_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_xfer),
        .i_action (i_action),
        .i_code   (i_code),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_res.line_level;
    assign o_busy_res   = r_res.busy_res;
    assign o_done_res   = r_res.done_res;

endmodule

`default_nettype wire

@@ rtl/ev1527_chk.sv @@
// Port-level checker for the EV1527 OOK frame encoder, with its bind.
// Depends on ev1527_ook_frame_encoder_assert.svh.
`default_nettype none

`include "ev1527_ook_frame_encoder_assert.svh"

module ev1527_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_line_level,
    input wire logic o_busy_res,
    input wire logic o_done_res
);
    logic       out_stall;
    logic [2:0] out_bits;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_bits  = {o_line_level, o_busy_res, o_done_res};

    `EV1527_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_bits))
    `EV1527_ASSERT_IMPL(a_stall_blocks_in, i_clk, i_rst_n, out_stall, !o_in_ready)
    `EV1527_ASSERT_NEXT(a_in_fills_out, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)
    `EV1527_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res && !o_line_level)
    `EV1527_ASSERT_IMPL(a_idle_low, i_clk, i_rst_n, o_out_valid && !o_busy_res, !o_line_level)

endmodule

bind ev1527_ook_frame_encoder ev1527_chk u_chk (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the EV1527 OOK frame encoder: directed and random traffic, with a
// built-in predictor of line level, busy and done. Depends on ev1527_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import ev1527_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int ITEM_COUNT  = 1700;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_action    = ACT_TICK;
    logic [CODE_W-1:0]    i_code      = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_ADDR;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_line_level;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic                 o_cfg_ready;

    ev1527_ook_frame_encoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_code       (i_code),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Encoder model state
    t_cfg                  model_cfg = '{device_address: ADDR_RST, short_ticks: SHORT_RST,
                                         long_ticks: LONG_RST, sync_gap_ticks: SYNC_RST,
                                         repeat_count: REPEAT_RST};
    logic                  tx_active       = 1'b0;
    logic [REPEAT_W-1:0]   frames_left     = '0;
    logic [SEG_W-1:0]      seg_idx         = '0;
    logic [CFG_W-1:0]      ticks_remaining = '0;
    logic [FRAME_BITS-1:0] frame_bits      = '0;
    logic                  line_hi         = 1'b0;

    t_result expected_line_states[$];
    int      mismatch_count  = 0;
    int      cycle_count     = 0;
    int      items_sent      = 0;
    int      hold_off_cycles = 0;
    int      ready_gap       = 0;
    bit      sender_idle_on   = 1'b1;
    bit      receiver_idle_on = 1'b1;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        else if (roll < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] fit_duration(logic [CFG_W-1:0] dur);
        return (dur == '0) ? CFG_W'(1) : dur;
    endfunction

    // Odd segments are low phases; a data segment is long when its level equals the bit.
    function automatic void load_segment();
        logic [CFG_W-1:0] dur;
        int               bit_pos;
        line_hi = ~seg_idx[0];
        if (seg_idx == 0) begin
            dur = model_cfg.short_ticks;
        end else if (seg_idx == 1) begin
            dur = model_cfg.sync_gap_ticks;
        end else begin
            bit_pos = (int'(seg_idx) - 2) >> 1;
            dur = (line_hi == frame_bits[FRAME_BITS-1-bit_pos]) ? model_cfg.long_ticks
                                                                : model_cfg.short_ticks;
        end
        ticks_remaining = fit_duration(dur);
    endfunction

    function automatic t_result advance_encoder(logic action, logic [CODE_W-1:0] code);
        t_result res;
        res = '0;
        if (action == ACT_START) begin
            if (!tx_active) begin
                frame_bits  = {model_cfg.device_address, code};
                frames_left = (model_cfg.repeat_count == '0) ? REPEAT_W'(1)
                                                             : model_cfg.repeat_count;
                seg_idx     = '0;
                tx_active   = 1'b1;
                load_segment();
            end
        end else if (tx_active) begin
            ticks_remaining = ticks_remaining - 1'b1;
            if (ticks_remaining == '0) begin
                seg_idx = seg_idx + 1'b1;
                if (seg_idx >= SEGS_PER_FRAME) begin
                    seg_idx     = '0;
                    frames_left = frames_left - 1'b1;
                    if (frames_left == '0) begin
                        tx_active    = 1'b0;
                        line_hi      = 1'b0;
                        res.done_res = 1'b1;
                    end
                end
                if (tx_active) load_segment();
            end
        end
        res.line_level = line_hi;
        res.busy_res   = tx_active;
        return res;
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_out_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (receiver_idle_on) ready_gap = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_line_states.size() == 0) begin
                $error("result transfer with no pending expectation");
                mismatch_count++;
            end else begin
                t_result exp_res;
                exp_res = expected_line_states.pop_front();
                if (o_line_level !== exp_res.line_level) begin
                    $error("line_level: expected %0d, actual %0d",
                           exp_res.line_level, o_line_level);
                    mismatch_count++;
                end
                if (o_busy_res !== exp_res.busy_res) begin
                    $error("busy_res: expected %0d, actual %0d", exp_res.busy_res, o_busy_res);
                    mismatch_count++;
                end
                if (o_done_res !== exp_res.done_res) begin
                    $error("done_res: expected %0d, actual %0d", exp_res.done_res, o_done_res);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic action, logic [CODE_W-1:0] code);
        int gap;
        gap = sender_idle_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_code     <= code;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        expected_line_states.push_back(advance_encoder(action, code));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_line_states.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_ADDR:   model_cfg.device_address = value;
            REG_SHORT:  model_cfg.short_ticks    = value;
            REG_LONG:   model_cfg.long_ticks     = value;
            REG_SYNC:   model_cfg.sync_gap_ticks = value;
            REG_REPEAT: model_cfg.repeat_count   = value[REPEAT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(int short_t, int long_t, int sync_t, int repeats);
        write_register(REG_SHORT, CFG_W'(short_t));
        write_register(REG_LONG, CFG_W'(long_t));
        write_register(REG_SYNC, CFG_W'(sync_t));
        write_register(REG_REPEAT, CFG_W'(repeats));
    endtask

    task automatic run_to_end();
        while (tx_active) send_item(ACT_TICK, CODE_W'($urandom));
    endtask

    task automatic test_idle_behavior();
        repeat (3) send_item(ACT_TICK, CODE_W'($urandom));
    endtask

    // Start on reset values, then shorten the durations mid-frame; repeats stay latched.
    task automatic test_default_settings();
        send_item(ACT_START, 8'h5A);
        repeat (5) send_item(ACT_TICK, 8'h00);
        send_item(ACT_START, 8'hFF);
        set_timing(1, 1, 1, 3);
        run_to_end();
        send_item(ACT_TICK, 8'hFF);
    endtask

    task automatic test_register_index();
        write_register(3'd5, 16'hFFFF);
        write_register(3'd6, 16'h0000);
        write_register(3'd7, 16'h1234);
        write_register(REG_ADDR, 16'hFFFF);
        set_timing(1, 2, 3, 1);
        send_item(ACT_START, 8'h00);
        repeat (4) send_item(ACT_TICK, 8'hFF);
        send_item(ACT_START, 8'hFF);
        run_to_end();
        write_register(REG_ADDR, 16'h0000);
        write_register(REG_REPEAT, 16'd1);
        send_item(ACT_START, 8'hFF);
        run_to_end();
    endtask

    // Zero durations count as one tick, zero repeats as one frame.
    task automatic test_zero_settings();
        write_register(REG_ADDR, 16'hA5C3);
        set_timing(0, 0, 0, 0);
        send_item(ACT_START, 8'h96);
        run_to_end();
    endtask

    // Back-to-back ticks; later writes change durations but not repeats or address.
    task automatic test_latched_settings();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        set_timing(40, 40, 40, 2);
        write_register(REG_ADDR, 16'hC35A);
        send_item(ACT_START, 8'h3C);
        repeat (10) send_item(ACT_TICK, 8'h00);
        set_timing(1, 0, 1, 1);
        write_register(REG_ADDR, 16'h5A5A);
        run_to_end();
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
    endtask

    // Hold the result side off while ticks keep coming, so the input stalls.
    task automatic test_backpressure();
        set_timing(2, 3, 4, 1);
        sender_idle_on = 1'b0;
        send_item(ACT_START, CODE_W'($urandom));
        hold_off_cycles = 300;
        repeat (40) send_item(ACT_TICK, CODE_W'($urandom));
        sender_idle_on = 1'b1;
        run_to_end();
    endtask

    task automatic test_random_traffic();
        int roll;
        while (items_sent < ITEM_COUNT) begin
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1)) write_register(REG_ADDR, CFG_W'($urandom));
            if ($urandom_range(0, 1))
                write_register(REG_SHORT, CFG_W'($urandom_range(0, 9) == 0 ? 0
                                                   : $urandom_range(1, 4)));
            if ($urandom_range(0, 1))
                write_register(REG_LONG, CFG_W'($urandom_range(0, 9) == 0 ? 0
                                                  : $urandom_range(1, 4)));
            if ($urandom_range(0, 1))
                write_register(REG_SYNC, CFG_W'($urandom_range(0, 8)));
            if ($urandom_range(0, 1))
                write_register(REG_REPEAT, CFG_W'($urandom_range(0, 9) == 0 ? 0
                                                    : $urandom_range(1, 2)));
            if ($urandom_range(0, 9) == 0)
                write_register(CFG_IDX_W'($urandom_range(5, 7)), CFG_W'($urandom));
            repeat ($urandom_range(0, 3)) send_item(ACT_TICK, CODE_W'($urandom));
            send_item(ACT_START, CODE_W'($urandom));
            while (tx_active) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    send_item(ACT_START, CODE_W'($urandom));
                end else if (roll < 5) begin
                    write_register($urandom_range(0, 1) ? REG_SHORT : REG_LONG,
                                   CFG_W'($urandom_range(1, 4)));
                end else begin
                    send_item(ACT_TICK, CODE_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_behavior();
        test_default_settings();
        test_register_index();
        test_zero_settings();
        test_latched_settings();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
